### design/chb_pkg.sv
// shared constants, types and codes for the clamped histogram bucketizer
// no dependencies; imported by every design file
package chb_pkg;

	localparam int NUM_BINS     = 16;
	localparam int COUNT_WIDTH  = 32;
	localparam int BIN_W        = $clog2(NUM_BINS);
	localparam int NBINS_W      = $clog2(NUM_BINS + 1);
	localparam int VALUE_W      = 32;
	localparam int STEP_W       = 32;
	localparam int MCOUNT_W     = 32;
	localparam int OUT_COUNT_W  = 32;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 32;
	localparam int NB_REG_W     = 5;
	localparam int QUOT_W       = BIN_W + 1;
	localparam int QBIT_W       = $clog2(QUOT_W);
	localparam int DIV_W        = STEP_W + QUOT_W - 1;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int MIN_BINS     = 2;

	localparam logic [NB_REG_W-1:0] NUM_BUCKETS_RST = NB_REG_W'(16);
	localparam logic [STEP_W-1:0]   BIN_STEP_RST    = STEP_W'(65536);

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_MERGE  = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_BUCKETS = 1'b0,
		CFG_BIN_STEP    = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_HOLD
	} front_state_t;

	typedef enum logic {
		B_IDLE,
		B_READ
	} back_state_t;

	// command word passed from front to back
	typedef struct packed {
		op_t                    op;
		logic [BIN_W-1:0]       idx;
		logic [COUNT_WIDTH-1:0] amount;
	} cmd_t;

endpackage

### design/clamped_histogram_bucketizer_core.sv
// top level of the clamped histogram bucketizer: config registers, front, queue, back
// depends on chb_pkg, chb_front, chb_queue, chb_back
//
// Equal-width histogram over 16 saturating 32-bit bins, cleared by reset. A non-negative
// sample is binned at the front by a shift-subtract divider that resolves one quotient
// bit per cycle: accept, five divider steps, then a hand-off that waits for queue space.
// A negative sample, merge, read or clear goes from accept to hand-off; a merge into a
// bin outside those in use is dropped at accept. A four-entry command queue separates
// front and back; the back applies one add or clear per cycle when no read runs, and
// streams bins in use, one word per cycle while out_ready allows; last marks the end.
// Config writes are always accepted and must be issued only while the block is idle.
module clamped_histogram_bucketizer_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [chb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [chb_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           operation,
	input  logic signed [chb_pkg::VALUE_W-1:0]   sample_value,
	input  logic [chb_pkg::BIN_W-1:0]            merge_index,
	input  logic [chb_pkg::MCOUNT_W-1:0]         merge_count,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [chb_pkg::BIN_W-1:0]            bin_index,
	output logic [chb_pkg::OUT_COUNT_W-1:0]      bin_count,
	output logic                                 last
);
	import chb_pkg::*;

	logic [NB_REG_W-1:0] num_buckets_q;
	logic [STEP_W-1:0]   bin_step_q;
	logic [NBINS_W-1:0]  num_bins;
	logic                push_valid, push_ready;
	logic                pop_valid, pop_ready;
	cmd_t                push_cmd, pop_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_buckets_q <= NUM_BUCKETS_RST;
			bin_step_q    <= BIN_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NUM_BUCKETS: num_buckets_q <= cfg_data[NB_REG_W-1:0];
				CFG_BIN_STEP:    bin_step_q    <= cfg_data[STEP_W-1:0];
				default:         bin_step_q    <= bin_step_q;
			endcase
		end
	end

	// bins in use, limited to between two and the store size
	always_comb begin
		if (num_buckets_q < NB_REG_W'(MIN_BINS)) begin
			num_bins = NBINS_W'(MIN_BINS);
		end else if (num_buckets_q > NB_REG_W'(NUM_BINS)) begin
			num_bins = NBINS_W'(NUM_BINS);
		end else begin
			num_bins = NBINS_W'(num_buckets_q);
		end
	end

	chb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.sample_value (sample_value),
		.merge_index  (merge_index),
		.merge_count  (merge_count),
		.num_bins     (num_bins),
		.bin_step     (bin_step_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_cmd     (push_cmd)
	);

	chb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	chb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.num_bins  (num_bins),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.bin_index (bin_index),
		.bin_count (bin_count),
		.last      (last)
	);

endmodule

### design/chb_front.sv
// front end: accepts items, bins samples with a shift-subtract divider, filters merges
// depends on chb_pkg
module chb_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         operation,
	input  logic signed [chb_pkg::VALUE_W-1:0] sample_value,
	input  logic [chb_pkg::BIN_W-1:0]          merge_index,
	input  logic [chb_pkg::MCOUNT_W-1:0]       merge_count,
	input  logic [chb_pkg::NBINS_W-1:0]        num_bins,
	input  logic [chb_pkg::STEP_W-1:0]         bin_step,
	output logic                               push_valid,
	input  logic                               push_ready,
	output chb_pkg::cmd_t                      push_cmd
);
	import chb_pkg::*;

	front_state_t            state_q, state_d;
	cmd_t                    cmd_q;
	logic [DIV_W-1:0]        rem_q;
	logic [STEP_W-1:0]       dstep_q;
	logic [QUOT_W-1:0]       quot_q;
	logic [QBIT_W-1:0]       qbit_q;

	logic                    accept;
	op_t                     in_op;
	logic [DIV_W-1:0]        trial;
	logic                    fits;
	logic [DIV_W-1:0]        rem_nxt;
	logic [QUOT_W-1:0]       quot_nxt;
	logic [BIN_W-1:0]        top_bin;
	logic [BIN_W-1:0]        clamped;
	logic                    merge_ok;

	assign in_ready = (state_q == F_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_op    = op_t'(operation);
	assign top_bin  = BIN_W'(num_bins - NBINS_W'(1));
	assign merge_ok = {1'b0, merge_index} < num_bins;

	// one quotient bit per cycle, msb first
	always_comb begin
		trial    = DIV_W'(dstep_q) << qbit_q;
		fits     = rem_q >= trial;
		rem_nxt  = fits ? (rem_q - trial) : rem_q;
		quot_nxt = quot_q;
		if (fits) begin
			quot_nxt[qbit_q] = 1'b1;
		end
		if (quot_nxt > QUOT_W'(top_bin)) begin
			clamped = top_bin;
		end else begin
			clamped = quot_nxt[BIN_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					case (in_op)
						OP_SAMPLE: state_d = sample_value[VALUE_W-1] ? F_HOLD : F_DIV;
						OP_MERGE:  state_d = merge_ok ? F_HOLD : F_IDLE;
						default:   state_d = F_HOLD;
					endcase
				end
			end
			F_DIV: begin
				if (qbit_q == '0) begin
					state_d = F_HOLD;
				end
			end
			F_HOLD: begin
				if (push_ready) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op <= in_op;
			rem_q    <= DIV_W'(sample_value[VALUE_W-2:0]);
			dstep_q  <= (bin_step == '0) ? STEP_W'(1) : bin_step;
			quot_q   <= '0;
			qbit_q   <= QBIT_W'(QUOT_W - 1);
			case (in_op)
				OP_SAMPLE: begin
					cmd_q.idx    <= '0;
					cmd_q.amount <= COUNT_WIDTH'(1);
				end
				OP_MERGE: begin
					cmd_q.idx    <= merge_index;
					cmd_q.amount <= COUNT_WIDTH'(merge_count);
				end
				default: begin
					cmd_q.idx    <= '0;
					cmd_q.amount <= '0;
				end
			endcase
		end else if (state_q == F_DIV) begin
			rem_q  <= rem_nxt;
			quot_q <= quot_nxt;
			qbit_q <= qbit_q - QBIT_W'(1);
			if (qbit_q == '0) begin
				cmd_q.idx <= clamped;
			end
		end
	end

	assign push_valid = (state_q == F_HOLD);
	assign push_cmd   = cmd_q;

endmodule

### design/chb_queue.sv
// small command queue between front and back
// depends on chb_pkg
module chb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  chb_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output chb_pkg::cmd_t pop_cmd
);
	import chb_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### design/chb_back.sv
// back end: bin count store, saturating updates, clear and read-out with output register
// depends on chb_pkg
module chb_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pop_valid,
	output logic                            pop_ready,
	input  chb_pkg::cmd_t                   pop_cmd,
	input  logic [chb_pkg::NBINS_W-1:0]     num_bins,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [chb_pkg::BIN_W-1:0]       bin_index,
	output logic [chb_pkg::OUT_COUNT_W-1:0] bin_count,
	output logic                            last
);
	import chb_pkg::*;

	back_state_t              state_q, state_d;
	logic [COUNT_WIDTH-1:0]   bins_q [NUM_BINS];
	logic [BIN_W-1:0]         rd_q;
	logic                     out_valid_q;
	logic [BIN_W-1:0]         out_idx_q;
	logic [OUT_COUNT_W-1:0]   out_cnt_q;
	logic                     out_last_q;

	logic                     do_pop;
	logic                     load_out;
	logic                     is_last;
	logic [BIN_W-1:0]         addr;
	logic [COUNT_WIDTH-1:0]   cur;
	logic [COUNT_WIDTH:0]     sum;
	logic [COUNT_WIDTH-1:0]   upd;
	logic [OUT_COUNT_W-1:0]   rep;

	assign pop_ready = (state_q == B_IDLE);
	assign do_pop    = pop_valid && pop_ready;
	assign load_out  = (state_q == B_READ) && (!out_valid_q || out_ready);
	assign is_last   = (rd_q == BIN_W'(num_bins - NBINS_W'(1)));
	assign addr      = (state_q == B_READ) ? rd_q : pop_cmd.idx;
	assign cur       = bins_q[addr];
	assign sum       = {1'b0, cur} + {1'b0, pop_cmd.amount};
	assign upd       = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

	// report saturates to the output width
	always_comb begin
		if (COUNT_WIDTH > OUT_COUNT_W && (cur >> OUT_COUNT_W) != '0) begin
			rep = '1;
		end else begin
			rep = OUT_COUNT_W'(cur);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (do_pop && pop_cmd.op == OP_READ) begin
					state_d = B_READ;
				end
			end
			B_READ: begin
				if (load_out && is_last) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			rd_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_BINS; i++) begin
				bins_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (do_pop) begin
				case (pop_cmd.op)
					OP_SAMPLE, OP_MERGE: bins_q[pop_cmd.idx] <= upd;
					OP_CLEAR: begin
						for (int i = 0; i < NUM_BINS; i++) begin
							bins_q[i] <= '0;
						end
					end
					OP_READ: rd_q <= '0;
					default: rd_q <= rd_q;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				rd_q        <= rd_q + BIN_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_idx_q  <= rd_q;
			out_cnt_q  <= rep;
			out_last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign bin_index = out_idx_q;
	assign bin_count = out_cnt_q;
	assign last      = out_last_q;

endmodule

### design/chb_checker.sv
// port-level checks on the bucketizer read-out stream, bound to the top level
// depends on chb_pkg and clamped_histogram_bucketizer_core
module chb_port_checks (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic [chb_pkg::BIN_W-1:0]            bin_index,
	input  logic [chb_pkg::OUT_COUNT_W-1:0]      bin_count,
	input  logic                                 last
);
	import chb_pkg::*;

	logic [BIN_W-1:0] exp_idx_q;

	// next bin expected in the read-out run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_valid && out_ready) begin
			exp_idx_q <= last ? '0 : (bin_index + BIN_W'(1));
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_index) &&
		$stable(bin_count) && $stable(last))
		else $error("result word changed while stalled");

	a_idx_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bin_index == exp_idx_q)
		else $error("read-out bin out of order");

	a_last_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> bin_index != '0)
		else $error("read-out run shorter than two bins");

endmodule

bind clamped_histogram_bucketizer_core chb_port_checks u_chb_port_checks (.*);

### verif/chb_checker.sv
// checker for clamped_histogram_bucketizer_core: watches config, sample and read-out channels
// keeps its own copy of the bins, predicts each read-out word and compares it field by field
// depends on chb_pkg
module chb_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [chb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [chb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [1:0]                      operation,
	input  logic [chb_pkg::VALUE_W-1:0]     sample_value,
	input  logic [chb_pkg::BIN_W-1:0]       merge_index,
	input  logic [chb_pkg::MCOUNT_W-1:0]    merge_count,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [chb_pkg::BIN_W-1:0]       bin_index,
	input  logic [chb_pkg::OUT_COUNT_W-1:0] bin_count,
	input  logic                            last,
	output int                              errors,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import chb_pkg::*;

	typedef struct packed {
		logic [BIN_W-1:0]       idx;
		logic [OUT_COUNT_W-1:0] cnt;
		logic                   last;
	} bin_report_t;

	bin_report_t            pending_reports[$];
	logic [COUNT_WIDTH-1:0] bin_tally[NUM_BINS];
	logic [NB_REG_W-1:0]    nb_reg;
	logic [STEP_W-1:0]      step_reg;

	function automatic int unsigned bins_in_use();
		int unsigned n;
		n = nb_reg;
		if (n < MIN_BINS) n = MIN_BINS;
		if (n > NUM_BINS) n = NUM_BINS;
		return n;
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_sum(logic [COUNT_WIDTH-1:0] a,
			logic [COUNT_WIDTH-1:0] b);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
	endfunction

	task automatic update_histogram(op_t op, logic [VALUE_W-1:0] value,
			logic [BIN_W-1:0] idx, logic [MCOUNT_W-1:0] amount);
		int unsigned n;
		int unsigned b;
		logic [STEP_W-1:0] divisor;
		logic [VALUE_W-1:0] quot;
		bin_report_t rep;
		n = bins_in_use();
		case (op)
			OP_SAMPLE: begin
				divisor = (step_reg == '0) ? STEP_W'(1) : step_reg;
				if (value[VALUE_W-1]) begin
					b = 0;
				end else begin
					quot = value / divisor;
					b = (quot > n - 1) ? n - 1 : quot;
				end
				bin_tally[b] = sat_sum(bin_tally[b], COUNT_WIDTH'(1));
			end
			OP_MERGE: begin
				if (idx < n) bin_tally[idx] = sat_sum(bin_tally[idx], COUNT_WIDTH'(amount));
			end
			OP_READ: begin
				for (int i = 0; i < n; i++) begin
					rep.idx  = BIN_W'(i);
					rep.cnt  = OUT_COUNT_W'(bin_tally[i]);
					rep.last = (i == n - 1);
					pending_reports.push_back(rep);
				end
			end
			default: begin
				for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		bin_report_t want;
		if (!arst_n) begin
			nb_reg   = NUM_BUCKETS_RST;
			step_reg = BIN_STEP_RST;
			for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
			pending_reports.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_reports.size() == 0) begin
					$error("read-out word with nothing expected: bin_index %0d bin_count %0d",
						bin_index, bin_count);
					errors++;
				end else begin
					want = pending_reports.pop_front();
					if (bin_index !== want.idx) begin
						$error("bin_index: expected %0d, got %0d", want.idx, bin_index);
						errors++;
					end
					if (bin_count !== want.cnt) begin
						$error("bin_count: expected %0d, got %0d", want.cnt, bin_count);
						errors++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_NUM_BUCKETS: nb_reg   = cfg_data[NB_REG_W-1:0];
					CFG_BIN_STEP:    step_reg = cfg_data[STEP_W-1:0];
					default:         ;
				endcase
			end
			if (in_valid && in_ready)
				update_histogram(op_t'(operation), sample_value, merge_index, merge_count);
			pending = pending_reports.size();
		end
	end

endmodule

### verif/clamped_histogram_bucketizer_core_tb.sv
// top of the clamped_histogram_bucketizer_core testbench: clock, reset, config writes,
// directed and random input words, read-out back-pressure and the final verdict
// depends on chb_pkg, chb_checker and the design
module clamped_histogram_bucketizer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import chb_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	cfg_idx_t               cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [1:0]             operation;
	logic [VALUE_W-1:0]     sample_value;
	logic [BIN_W-1:0]       merge_index;
	logic [MCOUNT_W-1:0]    merge_count;
	logic                   out_valid;
	logic                   out_ready;
	logic [BIN_W-1:0]       bin_index;
	logic [OUT_COUNT_W-1:0] bin_count;
	logic                   last;

	int   errors;
	int   pending;
	bit   steady;
	bit   holdoff_go;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	clamped_histogram_bucketizer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.sample_value (sample_value),
		.merge_index  (merge_index),
		.merge_count  (merge_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bin_index    (bin_index),
		.bin_count    (bin_count),
		.last         (last)
	);

	chb_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.sample_value (sample_value),
		.merge_index  (merge_index),
		.merge_count  (merge_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bin_index    (bin_index),
		.bin_count    (bin_count),
		.last         (last),
		.errors       (errors),
		.pending      (pending)
	);

	task automatic send_word(op_t op, logic [VALUE_W-1:0] value, logic [BIN_W-1:0] idx,
			logic [MCOUNT_W-1:0] cnt);
		if (!steady && $urandom_range(99) < 20) begin
			in_valid     <= 1'b0;
			operation    <= 2'($urandom);
			sample_value <= $urandom;
			merge_index  <= 4'($urandom);
			merge_count  <= $urandom;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		sample_value <= value;
		merge_index  <= idx;
		merge_count  <= cnt;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering words, wait out every expected read-out and the pipeline tail
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	// read-out back-pressure
	initial begin
		bit held_off;
		held_off  = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (holdoff_go && !held_off) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 20);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("clamped_histogram_bucketizer_core_tb: FAIL");
		$finish;
	end

	initial begin
		int unsigned phase_nb[8];
		logic [31:0] phase_step[8];
		int unsigned nb_eff;
		int          k;
		int unsigned r;
		longint      st;
		longint      v;
		op_t         op;
		logic [31:0] value;
		logic [3:0]  idx;
		logic [31:0] cnt;

		phase_nb   = '{16, 2, 1, 0, 31, 17, 8, 5};
		phase_step = '{32'd65536, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd3, 32'd0, 32'd0, 32'd0};
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_NUM_BUCKETS;
		cfg_data     = '0;
		in_valid     = 1'b0;
		operation    = OP_SAMPLE;
		sample_value = '0;
		merge_index  = '0;
		merge_count  = '0;
		steady       = 1'b0;
		holdoff_go   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 16 bins, step 1.0
		send_word(OP_SAMPLE, 32'h0000_0000, 4'd0, 32'd0);
		send_word(OP_SAMPLE, 32'h7FFF_FFFF, 4'd0, 32'd0);
		send_word(OP_SAMPLE, 32'h8000_0000, 4'd0, 32'd0);
		send_word(OP_SAMPLE, 32'hFFFF_FFFF, 4'd0, 32'd0);
		send_word(OP_SAMPLE, 32'h0000_FFFF, 4'd0, 32'd0);
		send_word(OP_SAMPLE, 32'h0001_0000, 4'd0, 32'd0);
		send_word(OP_SAMPLE, 32'h000F_0000, 4'd0, 32'd0);
		send_word(OP_SAMPLE, 32'h0010_0000, 4'd0, 32'd0);
		send_word(OP_MERGE, 32'd0, 4'd3, 32'd0);
		send_word(OP_MERGE, 32'd0, 4'd15, 32'hFFFF_FFFF);
		send_word(OP_SAMPLE, 32'h000F_8000, 4'd0, 32'd0);
		send_word(OP_MERGE, 32'd0, 4'd0, 32'hFFFF_FFFE);
		send_word(OP_MERGE, 32'd0, 4'd0, 32'd5);
		send_word(OP_READ, 32'd0, 4'd0, 32'd0);
		send_word(OP_CLEAR, 32'd0, 4'd0, 32'd0);
		send_word(OP_READ, 32'd0, 4'd0, 32'd0);
		drain_results();

		// two bins, zero step, merges past the bins in use
		write_reg(CFG_NUM_BUCKETS, 32'd2);
		write_reg(CFG_BIN_STEP, 32'd0);
		send_word(OP_SAMPLE, 32'd0, 4'd0, 32'd0);
		send_word(OP_SAMPLE, 32'd1, 4'd0, 32'd0);
		send_word(OP_SAMPLE, 32'd2, 4'd0, 32'd0);
		send_word(OP_MERGE, 32'd0, 4'd2, 32'd9);
		send_word(OP_MERGE, 32'd0, 4'd15, 32'd9);
		send_word(OP_MERGE, 32'd0, 4'd1, 32'd7);
		send_word(OP_READ, 32'd0, 4'd0, 32'd0);
		drain_results();

		// bin count below and above the range
		write_reg(CFG_NUM_BUCKETS, 32'd0);
		write_reg(CFG_BIN_STEP, 32'hFFFF_FFFF);
		send_word(OP_SAMPLE, 32'h7FFF_FFFF, 4'd0, 32'd0);
		send_word(OP_READ, 32'd0, 4'd0, 32'd0);
		drain_results();
		write_reg(CFG_NUM_BUCKETS, 32'd31);
		write_reg(CFG_BIN_STEP, 32'd1);
		send_word(OP_MERGE, 32'd0, 4'd15, 32'd3);
		send_word(OP_READ, 32'd0, 4'd0, 32'd0);

		for (int p = 0; p < 8; p++) begin
			drain_results();
			if (p >= 5)
				phase_step[p] = (p == 7) ? $urandom : $urandom_range(1, 1 << (8 * p - 24));
			write_reg(CFG_NUM_BUCKETS, {27'($urandom), 5'(phase_nb[p])});
			write_reg(CFG_BIN_STEP, phase_step[p]);
			nb_eff = phase_nb[p] < 2 ? 2 : (phase_nb[p] > 16 ? 16 : phase_nb[p]);
			st     = (phase_step[p] == 0) ? 1 : longint'(phase_step[p]);
			steady = (p == 3);
			if (p == 5) holdoff_go = 1'b1;
			for (int i = 0; i < 42; i++) begin
				r     = $urandom_range(99);
				value = $urandom;
				idx   = 4'($urandom);
				cnt   = $urandom_range(0, 1000);
				if (i == 41 || (p == 5 && i < 8)) op = OP_READ;
				else if (r < 55) op = OP_SAMPLE;
				else if (r < 75) op = OP_MERGE;
				else if (r < 93) op = OP_READ;
				else op = OP_CLEAR;
				if (op == OP_SAMPLE && $urandom_range(3) != 0) begin
					k = int'($urandom_range(0, nb_eff + 3)) - 2;
					v = k * st + longint'($urandom) % st;
					if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
					if (v < -64'sh8000_0000) v = -64'sh8000_0000;
					value = v[31:0];
				end
				if (op == OP_MERGE && $urandom_range(7) == 0) cnt = $urandom;
				if (op == OP_MERGE && $urandom_range(7) == 0) cnt = 32'hFFFF_FFF0 | 4'($urandom);
				send_word(op, value, idx, cnt);
			end
			steady = 1'b0;
		end
		drain_results();

		if (errors == 0)
			$display("clamped_histogram_bucketizer_core_tb: PASS");
		else
			$display("clamped_histogram_bucketizer_core_tb: FAIL");
		$finish;
	end

endmodule
